FILE: rtl/core/xrg_pkg.sv
// xrg_pkg: shared types and codes for the reversible xoshiro256 generator
// used by xrg_ctrl, xrg_datapath and the top level; no dependencies
package xrg_pkg;

	localparam int WORD_W   = 64;
	localparam int NUM_WORDS = 4;
	localparam int SEL_W    = 2;

	// item kinds
	localparam logic [1:0] KIND_FWD  = 2'd0;
	localparam logic [1:0] KIND_BWD  = 2'd1;
	localparam logic [1:0] KIND_LOAD = 2'd2;

	// scrambler codes
	localparam logic [1:0] MODE_STARSTAR = 2'd0;
	localparam logic [1:0] MODE_PLUS     = 2'd1;
	localparam logic [1:0] MODE_PLUSPLUS = 2'd2;

	// xoshiro256 constants
	localparam int SHIFT_A   = 17;
	localparam int ROT_B     = 45;
	localparam int ROT_PP    = 23;
	localparam int ROT_SS    = 7;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RETREAT,
		ST_SCR1,
		ST_SCR2
	} ctrl_state_t;

	typedef struct packed {
		logic load;     // write seed word on accept
		logic retreat;  // undo one advance
		logic scr1;     // first scrambler stage
		logic scr2;     // second scrambler stage, writes result
		logic forward;  // advance state together with scr2
	} dp_cmd_t;

	typedef struct packed {
		logic out_blocked;
	} dp_sts_t;

endpackage

FILE: rtl/core/xrg_ctrl.sv
// xrg_ctrl: sequencer for load, forward and backward items
// depends on xrg_pkg
module xrg_ctrl import xrg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] kind,
	output logic       in_stall,
	output dp_cmd_t    cmd,
	input  dp_sts_t    sts
);

	ctrl_state_t state_q, state_d;
	logic        fwd_q, fwd_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fwd_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			fwd_q   <= fwd_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		fwd_d       = fwd_q;
		cmd         = '0;
		cmd.forward = fwd_q;
		in_stall    = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (kind)
						KIND_FWD: begin
							fwd_d   = 1'b1;
							state_d = ST_SCR1;
						end
						KIND_BWD: begin
							fwd_d   = 1'b0;
							state_d = ST_RETREAT;
						end
						KIND_LOAD: cmd.load = 1'b1;
						default: ;  // unused kind is dropped
					endcase
				end
			end
			ST_RETREAT: begin
				cmd.retreat = 1'b1;
				state_d     = ST_SCR1;
			end
			ST_SCR1: begin
				cmd.scr1 = 1'b1;
				state_d  = ST_SCR2;
			end
			ST_SCR2: begin
				// hold while the previous word still waits
				if (!sts.out_blocked) begin
					cmd.scr2 = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

FILE: rtl/core/xrg_datapath.sv
// xrg_datapath: state words, advance/retreat logic, two-stage scrambler, output register
// depends on xrg_pkg
module xrg_datapath import xrg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	output dp_sts_t           sts,
	input  logic [1:0]        cfg_mode,
	input  logic [SEL_W-1:0]  word_select,
	input  logic [WORD_W-1:0] seed_word,
	input  logic              out_stall,
	output logic              out_valid,
	output logic [WORD_W-1:0] random_value
);

	logic [WORD_W-1:0] w_q [NUM_WORDS];
	logic [WORD_W-1:0] a_q, b_q, res_q;
	logic              out_valid_q;

	logic [WORD_W-1:0] adv [NUM_WORDS];
	logic [WORD_W-1:0] ret [NUM_WORDS];
	logic [WORD_W-1:0] t2, t3, w3r, u0, scr1_a, rot_a, scr2_r;

	function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int k);
		return (x << k) | (x >> (WORD_W - k));
	endfunction

	function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x, input int k);
		return (x >> k) | (x << (WORD_W - k));
	endfunction

	// x ^= x << 17 is its own inverse after three rounds
	function automatic logic [WORD_W-1:0] undo_shift(input logic [WORD_W-1:0] x);
		logic [WORD_W-1:0] y;
		y = x ^ (x << SHIFT_A);
		y = y ^ (y << SHIFT_A);
		y = y ^ (y << SHIFT_A);
		return y;
	endfunction

	// forward step
	always_comb begin
		t2     = w_q[2] ^ w_q[0];
		t3     = w_q[3] ^ w_q[1];
		adv[0] = w_q[0] ^ t3;
		adv[1] = w_q[1] ^ t2;
		adv[2] = t2 ^ (w_q[1] << SHIFT_A);
		adv[3] = rotl(t3, ROT_B);
	end

	// backward step
	always_comb begin
		w3r    = rotr(w_q[3], ROT_B);
		ret[0] = w_q[0] ^ w3r;
		u0     = undo_shift(w_q[1] ^ w_q[2]);
		ret[1] = u0;
		ret[2] = w_q[1] ^ ret[0] ^ u0;
		ret[3] = w3r ^ u0;
	end

	// scrambler, stage one: times five or the plain sum
	always_comb begin
		unique case (cfg_mode)
			MODE_STARSTAR: scr1_a = w_q[1] + (w_q[1] << 2);
			default:       scr1_a = w_q[0] + w_q[3];
		endcase
	end

	// stage two: rotate and times nine, pass, or rotate and add
	always_comb begin
		rot_a = rotl(a_q, ROT_SS);
		unique case (cfg_mode)
			MODE_STARSTAR: scr2_r = rot_a + (rot_a << 3);
			MODE_PLUS:     scr2_r = a_q;
			default:       scr2_r = rotl(a_q, ROT_PP) + b_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q[0] <= {{(WORD_W-1){1'b0}}, 1'b1};
			w_q[1] <= '1;
			w_q[2] <= {{(WORD_W-1){1'b0}}, 1'b1};
			w_q[3] <= '1;
		end else if (cmd.load) begin
			w_q[word_select] <= seed_word;
		end else if (cmd.retreat) begin
			w_q <= ret;
		end else if (cmd.scr2 && cmd.forward) begin
			w_q <= adv;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scr1) begin
			a_q <= scr1_a;
			b_q <= w_q[0];
		end
		if (cmd.scr2) begin
			res_q <= scr2_r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.scr2) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.out_blocked = out_valid_q && out_stall;
	assign out_valid       = out_valid_q;
	assign random_value    = res_q;

endmodule

FILE: rtl/core/xoshiro256_reversible_generator.sv
// xoshiro256_reversible_generator: top level, joins xrg_ctrl and xrg_datapath; uses xrg_pkg
// a forward step runs the two scrambler stages; a backward step runs the retreat first
// the input stays stalled until a step has written its word, and the last scrambler stage
// waits while the output word is stalled; a load gives no word and keeps the input open
// reset: state words 1, all ones, 1, all ones; scrambler starstar; output empty
module xoshiro256_reversible_generator import xrg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        kind,
	input  logic [SEL_W-1:0]  word_select,
	input  logic [WORD_W-1:0] seed_word,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [WORD_W-1:0] random_value
);

	logic [1:0] mode_q;
	dp_cmd_t    cmd;
	dp_sts_t    sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_STARSTAR;
		end else if (cfg_we) begin
			mode_q <= cfg_data;
		end
	end

	xrg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.kind     (kind),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	xrg_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_mode     (mode_q),
		.word_select  (word_select),
		.seed_word    (seed_word),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.random_value (random_value)
	);

endmodule

FILE: rtl/core/xrg_checker.sv
// xrg_checker: port-level assertions on the generator, bound to the top level
// depends on xrg_pkg
module xrg_checker import xrg_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic [1:0]        kind,
	input logic              out_valid,
	input logic              out_stall,
	input logic [WORD_W-1:0] random_value
);

	// a waiting word is neither dropped nor changed
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(random_value))
		else $error("stalled output word dropped or changed");

	// a step keeps the input closed for the next cycle
	a_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (kind == KIND_FWD || kind == KIND_BWD) |=> in_stall)
		else $error("input open right after a step");

	// a load finishes at once
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && kind == KIND_LOAD |=> !in_stall && !$rose(out_valid))
		else $error("load kept the input closed or made a word");

	// a new word only comes out of a step in progress
	a_word_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("word appeared with no step in progress");

endmodule

bind xoshiro256_reversible_generator xrg_checker u_xrg_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.kind         (kind),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.random_value (random_value)
);
